// ===== sv/crc12_mod3_frame_digest_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frame digest unit
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CRC12_MOD3_FRAME_DIGEST_UNIT_ASSERT_SVH
`define CRC12_MOD3_FRAME_DIGEST_UNIT_ASSERT_SVH

// same-cycle implication
`define CMFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cmfd_pkg.sv =====
// ---------------------------------------------------------------------------
// cmfd_pkg
// Widths, constants and byte-wide CRC-12 and modulo-3 helpers.
// ---------------------------------------------------------------------------
package cmfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 12;
  localparam int unsigned ResW     = 2;
  localparam int unsigned Modulus  = 3;
  localparam logic [CrcW-1:0] CrcPoly = 12'h80F;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int k = ByteW - 1; k >= 0; k--) begin
      fb = b[k] ^ c[CrcW-1];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // fold base-4 digits: 4 is congruent to 1 mod 3
  function automatic logic [ResW-1:0] mod3_byte(input logic [ByteW-1:0] b);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(b[7:6]) + 4'(b[5:4]) + 4'(b[3:2]) + 4'(b[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'(2 * Modulus)) begin
      t = t - 3'(2 * Modulus);
    end else if (t >= 3'(Modulus)) begin
      t = t - 3'(Modulus);
    end
    return t[ResW-1:0];
  endfunction

  function automatic logic [ResW-1:0] add_mod3(input logic [ResW-1:0] a,
                                               input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'(Modulus)) begin
      s = s - 3'(Modulus);
    end
    return s[ResW-1:0];
  endfunction

endpackage

// ===== sv/cmfd_in_if.sv =====
// ---------------------------------------------------------------------------
// cmfd_in_if
// Byte channel: valid/ready handshake with byte and frame markers.
// ---------------------------------------------------------------------------
interface cmfd_in_if import cmfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             frame_last;
  logic             stream_last;

  modport source (output valid, data_byte, frame_last, stream_last, input ready);
  modport sink   (input valid, data_byte, frame_last, stream_last, output ready);
endinterface

// ===== sv/cmfd_out_if.sv =====
// ---------------------------------------------------------------------------
// cmfd_out_if
// Result channel: valid/ready handshake with frame and digest values.
// ---------------------------------------------------------------------------
interface cmfd_out_if import cmfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CrcW-1:0] frame_crc;
  logic [ResW-1:0] frame_residue;
  logic [CrcW-1:0] digest_crc;
  logic [ResW-1:0] digest_residue;
  logic            stream_done;

  modport source (output valid, frame_crc, frame_residue, digest_crc, digest_residue,
                  stream_done, input ready);
  modport sink   (input valid, frame_crc, frame_residue, digest_crc, digest_residue,
                  stream_done, output ready);
endinterface

// ===== sv/crc12_mod3_frame_digest_unit.sv =====
// A frame's last byte enters the input register, then its result the output register.
// Throughput: one byte per cycle but for the hold below, set by the byte-wide CRC-12
// update that sits between the input register and the result register.
// A result waiting in the output register holds a frame's last byte in the input
// register until the result is taken; other bytes keep transferring.
// Reset clears the frame and digest accumulators and both valid flags.
// ---------------------------------------------------------------------------
// crc12_mod3_frame_digest_unit
// Per-frame CRC-12 and modulo-3 residue with a running stream digest.
// ---------------------------------------------------------------------------
`include "crc12_mod3_frame_digest_unit_assert.svh"

module crc12_mod3_frame_digest_unit import cmfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cmfd_in_if.sink           byte_i,
  cmfd_out_if.source        result_o
);

  logic             s1_vld_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_flast_q;
  logic             s1_slast_q;

  logic [CrcW-1:0]  frm_crc_q, frm_crc_d, frm_crc_nx;
  logic [ResW-1:0]  frm_res_q, frm_res_d, frm_res_nx;
  logic [CrcW-1:0]  dig_crc_q, dig_crc_d, dig_crc_nx;
  logic [ResW-1:0]  dig_res_q, dig_res_d, dig_res_nx;

  logic             o_vld_q, o_vld_d;
  logic [CrcW-1:0]  o_fcrc_q;
  logic [ResW-1:0]  o_fres_q;
  logic [CrcW-1:0]  o_dcrc_q;
  logic [ResW-1:0]  o_dres_q;
  logic             o_done_q;

  logic             out_free;
  logic             s1_adv;
  logic             in_rdy;
  logic             in_xfer;
  logic             res_load;

  assign out_free = !o_vld_q || result_o.ready;
  assign s1_adv   = s1_vld_q && (out_free || !s1_flast_q);
  assign in_rdy   = !s1_vld_q || s1_adv;
  assign in_xfer  = byte_i.valid && in_rdy;
  assign res_load = s1_adv && s1_flast_q;

  assign byte_i.ready = in_rdy;

  always_comb begin
    frm_crc_nx = crc_byte(frm_crc_q, s1_byte_q);
    frm_res_nx = add_mod3(frm_res_q, mod3_byte(s1_byte_q));
    dig_crc_nx = dig_crc_q ^ frm_crc_nx;
    dig_res_nx = add_mod3(dig_res_q, frm_res_nx);

    frm_crc_d = frm_crc_q;
    frm_res_d = frm_res_q;
    dig_crc_d = dig_crc_q;
    dig_res_d = dig_res_q;
    if (s1_adv) begin
      if (s1_flast_q) begin
        frm_crc_d = '0;
        frm_res_d = '0;
        if (s1_slast_q) begin
          dig_crc_d = '0;
          dig_res_d = '0;
        end else begin
          dig_crc_d = dig_crc_nx;
          dig_res_d = dig_res_nx;
        end
      end else begin
        frm_crc_d = frm_crc_nx;
        frm_res_d = frm_res_nx;
      end
    end

    o_vld_d = o_vld_q;
    if (res_load) begin
      o_vld_d = 1'b1;
    end else if (result_o.ready) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      o_vld_q   <= 1'b0;
      frm_crc_q <= '0;
      frm_res_q <= '0;
      dig_crc_q <= '0;
      dig_res_q <= '0;
    end else begin
      if (in_rdy) begin
        s1_vld_q <= byte_i.valid;
      end
      o_vld_q   <= o_vld_d;
      frm_crc_q <= frm_crc_d;
      frm_res_q <= frm_res_d;
      dig_crc_q <= dig_crc_d;
      dig_res_q <= dig_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= byte_i.data_byte;
      s1_flast_q <= byte_i.frame_last;
      s1_slast_q <= byte_i.stream_last;
    end
    if (res_load) begin
      o_fcrc_q <= frm_crc_nx;
      o_fres_q <= frm_res_nx;
      o_dcrc_q <= dig_crc_nx;
      o_dres_q <= dig_res_nx;
      o_done_q <= s1_slast_q;
    end
  end

  assign result_o.valid          = o_vld_q;
  assign result_o.frame_crc      = o_fcrc_q;
  assign result_o.frame_residue  = o_fres_q;
  assign result_o.digest_crc     = o_dcrc_q;
  assign result_o.digest_residue = o_dres_q;
  assign result_o.stream_done    = o_done_q;

  `CMFD_ASSERT_NOW(a_res_range, o_vld_q,
                   o_fres_q != 2'd3 && o_dres_q != 2'd3, "residue out of range")
  `CMFD_ASSERT_NEXT(a_res_load, res_load, o_vld_q, "frame end lost its result")
  `CMFD_ASSERT_NEXT(a_frm_clear, res_load,
                    frm_crc_q == '0 && frm_res_q == '0, "frame state not cleared")
  `CMFD_ASSERT_NEXT(a_dig_clear, res_load && s1_slast_q,
                    dig_crc_q == '0 && dig_res_q == '0, "digest not cleared")

endmodule

// ===== bench/crc12_mod3_frame_digest_unit_test.sv =====
// ---------------------------------------------------------------------------
// crc12_mod3_frame_digest_unit_test
// Self-checking bench for the frame digest unit. Bytes are sent in bursts
// with random gaps, and the result side stalls on a pattern of its own. Each
// byte transfer updates a local CRC-12 and modulo-3 predictor. Each result
// transfer is compared field by field with the oldest predicted frame result.
// ---------------------------------------------------------------------------
module crc12_mod3_frame_digest_unit_test;
  import cmfd_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             frame_last;
    logic             stream_last;
    logic             drain;
  } byte_item_t;

  typedef struct packed {
    logic [CrcW-1:0] frame_crc;
    logic [ResW-1:0] frame_residue;
    logic [CrcW-1:0] digest_crc;
    logic [ResW-1:0] digest_residue;
    logic            stream_done;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cmfd_in_if  byte_if ();
  cmfd_out_if result_if ();

  crc12_mod3_frame_digest_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  byte_item_t    pending_bytes[$];
  frame_result_t frames_due[$];
  int unsigned   mismatches = 0;

  logic [CrcW-1:0] frame_crc_q  = '0;
  logic [ResW-1:0] frame_res_q  = '0;
  logic [CrcW-1:0] digest_crc_q = '0;
  logic [ResW-1:0] digest_res_q = '0;

  int burst_left = 1;
  int gap_left   = 0;
  int unsigned stall_tick = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CrcW-1:0] crc12_step(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    r = crc ^ {b, 4'h0};
    for (int i = 0; i < ByteW; i++) begin
      if (r[CrcW-1]) begin
        r = (r << 1) ^ CrcPoly;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [ByteW-1:0] data, input logic flast,
                             input logic slast);
    frame_result_t res;
    frame_crc_q = crc12_step(frame_crc_q, data);
    frame_res_q = ResW'((int'(frame_res_q) + int'(data) % Modulus) % Modulus);
    if (flast) begin
      digest_crc_q = digest_crc_q ^ frame_crc_q;
      digest_res_q = ResW'((int'(digest_res_q) + int'(frame_res_q)) % Modulus);
      res.frame_crc      = frame_crc_q;
      res.frame_residue  = frame_res_q;
      res.digest_crc     = digest_crc_q;
      res.digest_residue = digest_res_q;
      res.stream_done    = slast;
      frames_due.push_back(res);
      frame_crc_q = '0;
      frame_res_q = '0;
      if (slast) begin
        digest_crc_q = '0;
        digest_res_q = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch %s: got %0h, want %0h", field, got, want);
  endtask

  task automatic add_byte(input logic [ByteW-1:0] data, input logic flast,
                          input logic slast, input logic drain);
    byte_item_t it;
    it.data        = data;
    it.frame_last  = flast;
    it.stream_last = slast;
    it.drain       = drain;
    pending_bytes.push_back(it);
  endtask

  function automatic logic ready_pattern(input int unsigned tick);
    case ((tick / 64) % 4)
      0: begin
        return 1'b1;
      end
      1: begin
        return 1'($urandom_range(0, 1));
      end
      2: begin
        return (tick % 3) == 0;
      end
      default: begin
        return (tick % 16) >= 10;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    byte_item_t nxt;
    if (!rst_ni) begin
      byte_if.valid       <= 1'b0;
      byte_if.data_byte   <= '0;
      byte_if.frame_last  <= 1'b0;
      byte_if.stream_last <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        absorb_byte(byte_if.data_byte, byte_if.frame_last, byte_if.stream_last);
      end
      if (byte_if.valid && !byte_if.ready) begin
        // hold the current transfer
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        byte_if.valid <= 1'b0;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].drain && frames_due.size() != 0)) begin
        byte_if.valid <= 1'b0;
      end else begin
        nxt = pending_bytes.pop_front();
        byte_if.valid       <= 1'b1;
        byte_if.data_byte   <= nxt.data;
        byte_if.frame_last  <= nxt.frame_last;
        byte_if.stream_last <= nxt.stream_last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    frame_result_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected result", result_if.frame_crc, 0);
        end else begin
          want = frames_due.pop_front();
          if (result_if.frame_crc !== want.frame_crc)
            report_mismatch("frame_crc", result_if.frame_crc, want.frame_crc);
          if (result_if.frame_residue !== want.frame_residue)
            report_mismatch("frame_residue", result_if.frame_residue, want.frame_residue);
          if (result_if.digest_crc !== want.digest_crc)
            report_mismatch("digest_crc", result_if.digest_crc, want.digest_crc);
          if (result_if.digest_residue !== want.digest_residue)
            report_mismatch("digest_residue", result_if.digest_residue,
                            want.digest_residue);
          if (result_if.stream_done !== want.stream_done)
            report_mismatch("stream_done", result_if.stream_done, want.stream_done);
        end
      end
      stall_tick = stall_tick + 1;
      result_if.ready <= ready_pattern(stall_tick);
    end
  end

  initial begin : stimulus_proc
    int nframes;
    int len;
    int sent;
    logic last_frame;
    logic last_byte;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = '0;
    byte_if.frame_last  = 1'b0;
    byte_if.stream_last = 1'b0;
    result_if.ready     = 1'b0;

    // single-byte frames at the byte extremes, then a four-byte frame
    add_byte(8'h00, 1'b1, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0, 1'b0);
    add_byte(8'h55, 1'b0, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b1, 1'b0, 1'b0);
    // stream end flagged without frame end is ignored
    add_byte(8'h7F, 1'b0, 1'b1, 1'b0);
    add_byte(8'h03, 1'b1, 1'b1, 1'b0);
    add_byte(8'hFE, 1'b1, 1'b1, 1'b0);
    // longer frame closing the stream
    for (int i = 0; i < 10; i++) begin
      add_byte(ByteW'(i * 37 + 5), 1'b0, 1'b0, 1'b0);
    end
    add_byte(8'hFE, 1'b1, 1'b1, 1'b0);
    // drain before the random part
    add_byte(8'h2C, 1'b1, 1'b1, 1'b1);

    sent = 0;
    while (sent < 400) begin
      nframes = $urandom_range(1, 5);
      for (int f = 0; f < nframes; f++) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 6);
        last_frame = (f == nframes - 1);
        for (int k = 0; k < len; k++) begin
          last_byte = (k == len - 1);
          add_byte(ByteW'($urandom_range(0, 255)), last_byte,
                   last_byte ? last_frame : 1'($urandom_range(0, 7) == 0),
                   (k == 0) && ($urandom_range(0, 30) == 0));
          sent++;
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || byte_if.valid || frames_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cmfd_pkg.sv
sv/cmfd_in_if.sv
sv/cmfd_out_if.sv
sv/crc12_mod3_frame_digest_unit.sv
bench/crc12_mod3_frame_digest_unit_test.sv
